@@ rtl/core/assert_macros.svh @@
// Assertion macros for the deframer RTL.
// Stands alone; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset
`define WSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, checked outside reset
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("deframer check failed");

`else

`define WSD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/wsd_pkg.sv @@
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by every deframer module.
package wsd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 64;
  localparam int unsigned KeyW  = 32;
  localparam int unsigned OpW   = 4;
  localparam int unsigned CntW  = 4;

  localparam logic [6:0] LenCode16 = 7'd126;
  localparam logic [6:0] LenCode64 = 7'd127;
  localparam logic [CntW-1:0] ExtBytes16 = 4'd2;
  localparam logic [CntW-1:0] ExtBytes64 = 4'd8;
  localparam logic [CntW-1:0] KeyBytes   = 4'd4;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  // One registered input byte
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
  } stage_t;

  // One result item
  typedef struct packed {
    logic             is_header;
    logic [OpW-1:0]   frame_opcode;
    logic             was_masked;
    logic [LenW-1:0]  frame_length;
    logic [ByteW-1:0] payload_byte;
    logic             last_of_frame;
  } result_t;

  // Parser status seen by the top level
  typedef struct packed {
    phase_t phase;
    logic   len_nonzero;
  } status_t;

endpackage

@@ rtl/core/wsd_ifs.sv @@
// Valid/ready channel interfaces for the deframer input and result streams.
// Depends on wsd_pkg for field widths.
interface wsd_byte_if import wsd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface wsd_result_if import wsd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             is_header;
  logic [OpW-1:0]   frame_opcode;
  logic             was_masked;
  logic [LenW-1:0]  frame_length;
  logic [ByteW-1:0] payload_byte;
  logic             last_of_frame;

  modport source (output valid, output is_header, output frame_opcode, output was_masked,
                  output frame_length, output payload_byte, output last_of_frame,
                  input ready);
  modport sink   (input valid, input is_header, input frame_opcode, input was_masked,
                  input frame_length, input payload_byte, input last_of_frame,
                  output ready);
endinterface

@@ rtl/core/wsd_in_stage.sv @@
// Input register: holds one accepted stream byte until the parser takes it.
// Depends on wsd_pkg.
module wsd_in_stage import wsd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] in_data,
  input  logic             advance,
  output stage_t           stage
);

  logic             valid_r;
  logic [ByteW-1:0] data_r;

  // Take a new request when empty or when the held byte moves on
  assign in_ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  // Payload holds without reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

  assign stage.valid = valid_r;
  assign stage.data  = data_r;

endmodule

@@ rtl/core/wsd_parser.sv @@
// Frame header parser and payload unmasker; one byte per advance.
// Depends on wsd_pkg.
module wsd_parser import wsd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic [ByteW-1:0] byte_in,
  output logic             res_valid,
  output result_t          res,
  output status_t          status
);

  phase_t          phase_r, phase_nxt;
  logic [OpW-1:0]  opcode_r, opcode_nxt;
  logic            mask_r, mask_nxt;
  logic [LenW-1:0] len_r, len_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [KeyW-1:0] key_r, key_nxt;
  logic [LenW-1:0] pos_r, pos_nxt;

  logic             do_after;
  logic             do_finish;
  logic [6:0]       len_code;
  logic [ByteW-1:0] key_byte;
  logic [LenW-1:0]  pos_inc;

  assign len_code = byte_in[6:0];
  assign pos_inc  = pos_r + 64'd1;

  // Pick the key byte for this payload position
  always_comb begin
    case (pos_r[1:0])
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // Next state and result for the byte at hand
  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    mask_nxt   = mask_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    key_nxt    = key_r;
    pos_nxt    = pos_r;
    do_after   = 1'b0;
    do_finish  = 1'b0;
    res_valid  = 1'b0;
    res.is_header     = 1'b0;
    res.payload_byte  = '0;
    res.last_of_frame = 1'b0;

    case (phase_r)
      PH_SECOND: begin
        mask_nxt = byte_in[7];
        if (len_code == LenCode16 || len_code == LenCode64) begin
          len_nxt   = '0;
          cnt_nxt   = (len_code == LenCode16) ? ExtBytes16 : ExtBytes64;
          phase_nxt = PH_EXTLEN;
        end else begin
          len_nxt  = {57'd0, len_code};
          do_after = 1'b1;
        end
      end
      PH_EXTLEN: begin
        len_nxt = {len_r[LenW-ByteW-1:0], byte_in};
        cnt_nxt = cnt_r - 4'd1;
        do_after = (cnt_nxt == '0);
      end
      PH_KEY: begin
        key_nxt = {key_r[KeyW-ByteW-1:0], byte_in};
        cnt_nxt = cnt_r - 4'd1;
        do_finish = (cnt_nxt == '0);
      end
      PH_PAYLOAD: begin
        res_valid         = 1'b1;
        res.payload_byte  = mask_r ? (byte_in ^ key_byte) : byte_in;
        res.last_of_frame = (pos_inc == len_r);
        pos_nxt           = pos_inc;
        if (res.last_of_frame) begin
          phase_nxt = PH_FIRST;
        end
      end
      default: begin
        opcode_nxt = byte_in[OpW-1:0];
        phase_nxt  = PH_SECOND;
      end
    endcase

    // Length done: collect a key or close the header
    if (do_after) begin
      if (mask_nxt) begin
        phase_nxt = PH_KEY;
        cnt_nxt   = KeyBytes;
        key_nxt   = '0;
      end else begin
        do_finish = 1'b1;
      end
    end

    // Header done: emit the header result
    if (do_finish) begin
      pos_nxt           = '0;
      res_valid         = 1'b1;
      res.is_header     = 1'b1;
      res.last_of_frame = (len_nxt == '0);
      phase_nxt         = res.last_of_frame ? PH_FIRST : PH_PAYLOAD;
    end

    res.frame_opcode = opcode_nxt;
    res.was_masked   = mask_nxt;
    res.frame_length = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FIRST;
      opcode_r <= '0;
      mask_r   <= 1'b0;
      len_r    <= '0;
      cnt_r    <= '0;
      key_r    <= '0;
      pos_r    <= '0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      mask_r   <= mask_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      key_r    <= key_nxt;
      pos_r    <= pos_nxt;
    end
  end

  assign status.phase       = phase_r;
  assign status.len_nonzero = (len_r != '0);

endmodule

@@ rtl/core/wsd_out_stage.sv @@
// Result register: holds one result until the downstream side takes it.
// Depends on wsd_pkg.
module wsd_out_stage import wsd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    stage_valid,
  input  logic    res_valid,
  input  result_t res,
  input  logic    out_ready,
  output logic    advance,
  output logic    out_valid,
  output result_t out_res
);

  logic    valid_r;
  result_t res_r;

  // Move the held byte on when the result slot is free or draining
  assign advance = stage_valid && (!valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= res_valid;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

@@ rtl/core/websocket_frame_deframer.sv @@
// WebSocket frame deframer top level: input register, parser, result register.
// Depends on wsd_pkg, wsd_ifs, wsd_in_stage, wsd_parser, wsd_out_stage.
//
//   channel   dir  payload                                        handshake
//   in_bus    in   stream_byte                                    valid/ready
//   out_bus   out  is_header, frame_opcode, was_masked,           valid/ready
//                  frame_length, payload_byte, last_of_frame
//
// One byte per cycle sustained while the result side is ready; a taken byte waits in the
// input register and is parsed into the result register when it moves on.
// Header bytes other than the one that completes the header give no result.
// rst_n is synchronous; all parse state returns to awaiting a first header byte.
// A stalled result still lets one more byte enter the input register.
`include "assert_macros.svh"

module websocket_frame_deframer import wsd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  wsd_byte_if.sink      in_bus,
  wsd_result_if.source  out_bus
);

  stage_t  stage;
  logic    advance;
  logic    res_valid;
  result_t res;
  result_t out_res;
  status_t status;

  wsd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .in_data  (in_bus.stream_byte),
    .advance  (advance),
    .stage    (stage)
  );

  wsd_parser u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .byte_in   (stage.data),
    .res_valid (res_valid),
    .res       (res),
    .status    (status)
  );

  wsd_out_stage u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .stage_valid (stage.valid),
    .res_valid   (res_valid),
    .res         (res),
    .out_ready   (out_bus.ready),
    .advance     (advance),
    .out_valid   (out_bus.valid),
    .out_res     (out_res)
  );

  assign out_bus.is_header     = out_res.is_header;
  assign out_bus.frame_opcode  = out_res.frame_opcode;
  assign out_bus.was_masked    = out_res.was_masked;
  assign out_bus.frame_length  = out_res.frame_length;
  assign out_bus.payload_byte  = out_res.payload_byte;
  assign out_bus.last_of_frame = out_res.last_of_frame;

  // A header that ends its frame declares an empty payload
  `WSD_ASSERT_NOW(a_hdr_last_empty, clk, rst_n,
    out_bus.valid && out_bus.is_header, out_bus.last_of_frame == (out_bus.frame_length == '0))
  // Payload phase is entered only for a nonempty frame
  `WSD_ASSERT_NOW(a_payload_len, clk, rst_n, status.phase == PH_PAYLOAD, status.len_nonzero)
  // A held byte that cannot move on stays held
  `WSD_ASSERT_NEXT(a_stage_hold, clk, rst_n, stage.valid && !advance, stage.valid)

endmodule

@@ sim/tb_websocket_frame_deframer.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for websocket_frame_deframer: byte stream in, header/payload out.
// Depends on wsd_pkg and the wsd_byte_if / wsd_result_if channel interfaces.
module tb_websocket_frame_deframer import wsd_pkg::*; ();

  localparam int unsigned HoldCycles   = 200;
  localparam int unsigned RandomBytes  = 1100;
  localparam int unsigned DrainLimit   = 20000;
  localparam int unsigned SettleCycles = 8;

  typedef enum logic [1:0] {
    FORM_SHORT,
    FORM_EXT16,
    FORM_EXT64
  } len_form_t;

  logic clk = 1'b0;
  logic rst_n;

  wsd_byte_if   in_if ();
  wsd_result_if out_if ();

  websocket_frame_deframer DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if)
  );

  always #1 clk = ~clk;

  // Traffic shaping, shared by the sender and the result-ready process
  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct       = 0;
  logic        hold_toggle     = 1'b0;
  int unsigned bytes_taken     = 0;
  int unsigned error_count     = 0;

  // Deframer shadow state
  phase_t      rx_phase  = PH_FIRST;
  logic [3:0]  rx_opcode = '0;
  logic        rx_masked = 1'b0;
  logic [63:0] rx_length = '0;
  logic [3:0]  rx_count  = '0;
  logic [31:0] rx_key    = '0;
  logic [63:0] rx_pos    = '0;

  result_t deframed_q [$];

  // Queue one result built from the current frame state
  function automatic void queue_result(input logic hdr, input logic [7:0] pb, input logic last);
    result_t r;
    r.is_header     = hdr;
    r.frame_opcode  = rx_opcode;
    r.was_masked    = rx_masked;
    r.frame_length  = rx_length;
    r.payload_byte  = pb;
    r.last_of_frame = last;
    deframed_q.push_back(r);
  endfunction

  // Header done: emit the header result, then payload or a new frame
  function automatic void close_header();
    rx_pos = '0;
    if (rx_length == 0) begin
      rx_phase = PH_FIRST;
      queue_result(1'b1, 8'h00, 1'b1);
    end else begin
      rx_phase = PH_PAYLOAD;
      queue_result(1'b1, 8'h00, 1'b0);
    end
  endfunction

  // Length done: collect the key if masked, else close the header
  function automatic void close_length();
    if (rx_masked) begin
      rx_phase = PH_KEY;
      rx_count = KeyBytes;
      rx_key   = '0;
    end else begin
      close_header();
    end
  endfunction

  // Advance the shadow parser by one accepted stream byte
  function automatic void deframe_byte(input logic [7:0] b);
    logic [7:0] kb;
    logic       last;
    case (rx_phase)
      PH_SECOND: begin
        rx_masked = b[7];
        if (b[6:0] == LenCode16 || b[6:0] == LenCode64) begin
          rx_length = '0;
          rx_count  = (b[6:0] == LenCode16) ? ExtBytes16 : ExtBytes64;
          rx_phase  = PH_EXTLEN;
        end else begin
          rx_length = 64'(b[6:0]);
          close_length();
        end
      end
      PH_EXTLEN: begin
        rx_length = {rx_length[55:0], b};
        rx_count  = rx_count - 4'd1;
        if (rx_count == 0) close_length();
      end
      PH_KEY: begin
        rx_key   = {rx_key[23:0], b};
        rx_count = rx_count - 4'd1;
        if (rx_count == 0) close_header();
      end
      PH_PAYLOAD: begin
        kb   = rx_masked ? rx_key[31 - 8*rx_pos[1:0] -: 8] : 8'h00;
        last = (rx_pos + 64'd1 == rx_length);
        queue_result(1'b0, b ^ kb, last);
        rx_pos = rx_pos + 64'd1;
        if (last) rx_phase = PH_FIRST;
      end
      default: begin
        rx_opcode = b[3:0];
        rx_phase  = PH_SECOND;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Check each accepted result, then predict from each accepted request
  always @(posedge clk) begin : scoreboard
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (deframed_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none actual hdr=%0b op=%0h len=%0h byte=%0h",
                 $time, out_if.is_header, out_if.frame_opcode, out_if.frame_length,
                 out_if.payload_byte);
        error_count++;
      end else begin
        want = deframed_q.pop_front();
        check_field("is_header", want.is_header, out_if.is_header);
        check_field("frame_opcode", want.frame_opcode, out_if.frame_opcode);
        check_field("was_masked", want.was_masked, out_if.was_masked);
        check_field("frame_length", want.frame_length, out_if.frame_length);
        check_field("payload_byte", want.payload_byte, out_if.payload_byte);
        check_field("last_of_frame", want.last_of_frame, out_if.last_of_frame);
      end
    end
    if (rst_n && in_if.valid && in_if.ready) deframe_byte(in_if.stream_byte);
  end

  // Drive result ready: random stalls, plus a long hold-off on request
  initial begin : result_ready_drive
    int unsigned hold_left;
    logic        hold_seen;
    hold_left    = 0;
    hold_seen    = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one byte after a random gap and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.stream_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    bytes_taken++;
  endtask

  // Send a whole frame with random payload bytes
  task automatic send_frame(input logic [7:0] first, input logic masked, input len_form_t form,
                            input logic [63:0] len, input logic [31:0] key);
    longint unsigned i;
    int              k;
    send_byte(first);
    case (form)
      FORM_EXT16: begin
        send_byte({masked, LenCode16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      FORM_EXT64: begin
        send_byte({masked, LenCode64});
        for (k = 7; k >= 0; k--) send_byte(len[8*k +: 8]);
      end
      default: send_byte({masked, len[6:0]});
    endcase
    if (masked) for (k = 3; k >= 0; k--) send_byte(key[8*k +: 8]);
    for (i = 0; i < len; i++) send_byte(8'($urandom));
  endtask

  // Mostly short frames; some extended encodings, minimal or not
  task automatic send_random_frame();
    int unsigned pick;
    logic [63:0] len;
    len_form_t   form;
    pick = $urandom_range(99);
    form = FORM_SHORT;
    if (pick < 55) begin
      len = $urandom_range(12);
    end else if (pick < 80) begin
      len = $urandom_range(125);
    end else begin
      len = (pick < 94) ? $urandom_range(40) : $urandom_range(300, 126);
      if ($urandom_range(1)) form = FORM_EXT64;
      else form = FORM_EXT16;
    end
    send_frame(8'($urandom), 1'($urandom), form, len, $urandom);
  endtask

  // Zero-length frames, key wrap, non-minimal 16-bit length
  task automatic test_short_frames();
    sender_idle_pct = 0;
    stall_pct      <= 0;
    // unmasked, zero length, FIN and RSV bits set
    send_byte(8'hF9); send_byte(8'h00);
    // masked, zero length: header result comes on the last key byte
    send_byte(8'h80); send_byte(8'h80);
    send_byte(8'hFF); send_byte(8'h00); send_byte(8'hA5); send_byte(8'h5A);
    // masked, five bytes: key index wraps past four
    send_byte(8'h0F); send_byte(8'h85);
    send_byte(8'h12); send_byte(8'h34); send_byte(8'h56); send_byte(8'h78);
    send_byte(8'h00); send_byte(8'hFF); send_byte(8'h12); send_byte(8'h34); send_byte(8'h56);
    // two bytes in a 16-bit length field
    send_byte(8'h02); send_byte(8'h7E); send_byte(8'h00); send_byte(8'h02);
    send_byte(8'hAA); send_byte(8'h55);
  endtask

  // Hold off results for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    sender_idle_pct = 0;
    stall_pct      <= 0;
    hold_toggle    <= ~hold_toggle;
    send_frame(8'h81, 1'b1, FORM_EXT16, 64'd150, $urandom);
  endtask

  // Random frames across the idling phases
  task automatic test_random_traffic();
    int unsigned goal;
    int          ph;
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  stall_pct <= 0;  end
        1: begin sender_idle_pct = 83; stall_pct <= 0;  end
        2: begin sender_idle_pct = 0;  stall_pct <= 83; end
        default: begin sender_idle_pct = 37; stall_pct <= 37; end
      endcase
      goal = bytes_taken + RandomBytes / 4;
      while (bytes_taken < goal) send_random_frame();
    end
  endtask

  // All-ones 64-bit length: frame never ends, so this runs last
  task automatic test_oversized_length();
    int k;
    sender_idle_pct = 37;
    stall_pct      <= 37;
    send_byte(8'h08); send_byte(8'hFF);
    for (k = 0; k < 8; k++) send_byte(8'hFF);
    send_byte(8'h01); send_byte(8'h02); send_byte(8'h03); send_byte(8'h04);
    for (k = 0; k < 6; k++) send_byte(8'($urandom));
  endtask

  initial begin : run_tests
    int unsigned guard;
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.stream_byte = 8'h00;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_frames();
    test_backpressure();
    test_random_traffic();
    test_oversized_length();

    // Drop valid and drain outstanding results
    in_if.valid <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (deframed_q.size() != 0 && guard < DrainLimit);
    repeat (SettleCycles) @(posedge clk);
    if (deframed_q.size() != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time, deframed_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("tb_websocket_frame_deframer OK");
    end else begin
      $display("tb_websocket_frame_deframer NOT OK");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs
  initial begin : watchdog
    #2000000;
    $display("%0t ns: timeout", $time);
    $display("tb_websocket_frame_deframer NOT OK");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/wsd_pkg.sv
rtl/core/wsd_ifs.sv
rtl/core/wsd_in_stage.sv
rtl/core/wsd_parser.sv
rtl/core/wsd_out_stage.sv
rtl/core/websocket_frame_deframer.sv
sim/tb_websocket_frame_deframer.sv
